// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while reset is asserted
`define HZS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define HZS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/hzs_pkg.sv
// shared constants and types for the shock switch pipeline
// no dependencies
`timescale 1ns / 1ps
package hzs_pkg;
  // default sample width
  localparam int HZS_SAMPLE_BITS = 24;
  // ratio quotient bits, q in q0.16
  localparam int Q_BITS = 16;
  // every term of the ratio is scaled by this
  localparam logic [9:0] SCALE = 10'd1000;
  // 1.0 in q1.15
  localparam logic [15:0] ONE_Q15 = 16'd32768;
  // register stages of the front and back ends
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES = 3;

  // control that travels with each transaction
  typedef struct packed {
    logic valid;
    logic shock;
  } ctl_t;
endpackage

// File: sv/hzs_front.sv
// front end: differences, magnitudes, ratio terms and the shock test
// depends on hzs_pkg
`timescale 1ns / 1ps
module hzs_front #(
  parameter int N = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [N-1:0]           left_sample,
  input  logic [N-1:0]           center_sample,
  input  logic [N-1:0]           right_sample,
  output hzs_pkg::ctl_t          ctl,
  output logic [N+10:0]          num,
  output logic [N+11:0]          den
);
  import hzs_pkg::*;

  localparam int DW   = N + 1;
  localparam int NUMW = N + 11;
  localparam int DENW = N + 12;
  localparam int PW   = 2 * DW;
  localparam int CW   = PW + 10;

  // stage 1: differences and magnitudes
  logic signed [DW-1:0] d1, d2;
  logic [N-1:0]  ml, mc, mr;
  logic [DW-1:0] s1_nxt, s2_nxt, f1_nxt;
  logic opp_nxt;
  logic [DW-1:0] s1_r, s2_r, f1_r;
  logic opp_r, v1_r;

  always_comb begin
    d1 = $signed({center_sample[N-1], center_sample}) - $signed({left_sample[N-1], left_sample});
    d2 = $signed({right_sample[N-1], right_sample}) - $signed({center_sample[N-1], center_sample});
    s1_nxt = d1[DW-1] ? DW'(-d1) : DW'(d1);
    s2_nxt = d2[DW-1] ? DW'(-d2) : DW'(d2);
    ml = left_sample[N-1] ? N'(-left_sample) : left_sample;
    mc = center_sample[N-1] ? N'(-center_sample) : center_sample;
    mr = right_sample[N-1] ? N'(-right_sample) : right_sample;
    f1_nxt = DW'(ml) + DW'(mc) + DW'(mr);
    opp_nxt = (d1[DW-1] && (d2 != '0) && !d2[DW-1]) ||
              (d2[DW-1] && (d1 != '0) && !d1[DW-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    f1_r  <= f1_nxt;
    opp_r <= opp_nxt;
  end

  // stage 2: scaled numerator, denominator and test products
  logic [DW-1:0]   diff;
  logic [NUMW-1:0] num_nxt, num2_r;
  logic [DENW-1:0] den_nxt, den2_r;
  logic [PW-1:0]   prod_nxt, fsq_nxt, prod_r, fsq_r;
  logic opp2_r, v2_r;

  always_comb begin
    diff = (s1_r > s2_r) ? s1_r - s2_r : s2_r - s1_r;
    num_nxt = NUMW'(diff) * NUMW'(SCALE);
    den_nxt = DENW'(DENW'(s1_r) + DENW'(s2_r)) * DENW'(SCALE) +
              DENW'(f1_r) * DENW'(3) + DENW'(SCALE);
    prod_nxt = PW'(s1_r) * PW'(s2_r);
    fsq_nxt  = PW'(f1_r) * PW'(f1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    num2_r <= num_nxt;
    den2_r <= den_nxt;
    prod_r <= prod_nxt;
    fsq_r  <= fsq_nxt;
    opp2_r <= opp_r;
  end

  // stage 3: shock test, 1000*s1*s2 > f1^2 with opposite signs
  logic shock_nxt;
  ctl_t ctl_r;
  logic [NUMW-1:0] num3_r;
  logic [DENW-1:0] den3_r;

  assign shock_nxt = opp2_r && ((CW'(prod_r) * CW'(SCALE)) > CW'(fsq_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= v2_r;
    end
    ctl_r.shock <= shock_nxt;
    num3_r <= num2_r;
    den3_r <= den2_r;
  end

  assign ctl = ctl_r;
  assign num = num3_r;
  assign den = den3_r;
endmodule

// File: sv/hzs_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on hzs_pkg
`timescale 1ns / 1ps
module hzs_div #(
  parameter int NUMW = 35,
  parameter int DENW = 36
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hzs_pkg::ctl_t       ctl_in,
  input  logic [NUMW-1:0]     num,
  input  logic [DENW-1:0]     den,
  output hzs_pkg::ctl_t       ctl_out,
  output logic [hzs_pkg::Q_BITS-1:0] quo
);
  import hzs_pkg::*;

  // stage registers; remainder stays below the divisor
  ctl_t            ctl_r [Q_BITS];
  logic [DENW-1:0] rem_r [Q_BITS];
  logic [DENW-1:0] den_r [Q_BITS];
  logic [Q_BITS-1:0] q_r [Q_BITS];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_step
    ctl_t            c_prev;
    logic [DENW-1:0] rem_prev, den_prev;
    logic [Q_BITS-1:0] q_prev;
    logic [DENW:0]   two;
    logic            ge;
    logic [DENW-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign c_prev   = ctl_in;
      assign rem_prev = DENW'(num);
      assign den_prev = den;
      assign q_prev   = '0;
    end else begin : g_rest
      assign c_prev   = ctl_r[i-1];
      assign rem_prev = rem_r[i-1];
      assign den_prev = den_r[i-1];
      assign q_prev   = q_r[i-1];
    end

    // shift in one bit and subtract when it fits
    always_comb begin
      two = {rem_prev, 1'b0};
      ge = two >= {1'b0, den_prev};
      rem_nxt = ge ? DENW'(two - {1'b0, den_prev}) : DENW'(two);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i].valid <= 1'b0;
      end else begin
        ctl_r[i].valid <= c_prev.valid;
      end
      ctl_r[i].shock <= c_prev.shock;
      rem_r[i] <= rem_nxt;
      den_r[i] <= den_prev;
      q_r[i]   <= {q_prev[Q_BITS-2:0], ge};
    end
  end

  assign ctl_out = ctl_r[Q_BITS-1];
  assign quo     = q_r[Q_BITS-1];
endmodule

// File: sv/hzs_back.sv
// back end: fourth power of the ratio, clip and shock override
// depends on hzs_pkg
`timescale 1ns / 1ps
module hzs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hzs_pkg::ctl_t              ctl_in,
  input  logic [hzs_pkg::Q_BITS-1:0] quo,
  output logic                       out_valid,
  output logic [15:0]                out_coef
);
  import hzs_pkg::*;

  localparam int SQW = 2 * Q_BITS;

  // square of the ratio
  logic [SQW-1:0] sq1, sq2;
  logic [Q_BITS-1:0] r2_r, r4_r;
  ctl_t c1_r, c2_r;

  assign sq1 = SQW'(quo) * SQW'(quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
    end else begin
      c1_r.valid <= ctl_in.valid;
    end
    c1_r.shock <= ctl_in.shock;
    r2_r <= sq1[SQW-1:Q_BITS];
  end

  // fourth power
  assign sq2 = SQW'(r2_r) * SQW'(r2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r.valid <= 1'b0;
    end else begin
      c2_r.valid <= c1_r.valid;
    end
    c2_r.shock <= c1_r.shock;
    r4_r <= sq2[SQW-1:Q_BITS];
  end

  // clip to 1.0, shock forces 1.0
  logic [15:0] coef_nxt, coef_r;
  logic        valid_r;

  always_comb begin
    if (c2_r.shock || (16'(r4_r) > ONE_Q15)) begin
      coef_nxt = ONE_Q15;
    end else begin
      coef_nxt = 16'(r4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= c2_r.valid;
    end
    coef_r <= coef_nxt;
  end

  assign out_valid = valid_r;
  assign out_coef  = coef_r;
endmodule

// File: sv/harten_zwas_switch.sv
// top level of the shock switch: front end, divider and back end
// depends on hzs_pkg, hzs_front, hzs_div, hzs_back, assert_macros.svh
`timescale 1ns / 1ps
// Takes one stencil triple per clock whenever start is high and busy is low;
// busy is high only during reset. Each transaction comes out on out_switch_coef
// with a one-cycle out_valid strobe after it has passed through
// 3 front-end stages, 16 divider stages (one quotient bit each) and 3 back-end
// stages. The receiver cannot stall, so nothing ever holds the pipeline.
// A reset drops all transactions in flight.
`include "assert_macros.svh"
module harten_zwas_switch #(
  parameter int SAMPLE_BITS = hzs_pkg::HZS_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] in_left_sample,
  input  logic [SAMPLE_BITS-1:0] in_center_sample,
  input  logic [SAMPLE_BITS-1:0] in_right_sample,
  output logic                   out_valid,
  output logic [15:0]            out_switch_coef
);
  import hzs_pkg::*;

  localparam int NUMW = SAMPLE_BITS + 11;
  localparam int DENW = SAMPLE_BITS + 12;
  localparam int LAT  = FRONT_STAGES + Q_BITS + BACK_STAGES;

  ctl_t ctl_f, ctl_d;
  logic [NUMW-1:0] num;
  logic [DENW-1:0] den;
  logic [Q_BITS-1:0] quo;

  // accept every cycle outside reset
  assign busy = !rst_n;

  hzs_front #(.N(SAMPLE_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (start && !busy),
    .left_sample   (in_left_sample),
    .center_sample (in_center_sample),
    .right_sample  (in_right_sample),
    .ctl           (ctl_f),
    .num           (num),
    .den           (den)
  );

  hzs_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_f),
    .num     (num),
    .den     (den),
    .ctl_out (ctl_d),
    .quo     (quo)
  );

  hzs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_d),
    .quo       (quo),
    .out_valid (out_valid),
    .out_coef  (out_switch_coef)
  );

  // every result stems from a transaction accepted at the pipeline input
  `HZS_ASSERT_ALWAYS(a_latency, clk, out_valid |-> $past(start && !busy, LAT), "result without transaction")
  // result never exceeds 1.0
  `HZS_ASSERT(a_range, clk, rst_n, out_valid |-> (out_switch_coef <= ONE_Q15), "coef above one")
  // reset empties the pipeline
  `HZS_ASSERT_ALWAYS(a_flush, clk, !rst_n |=> !out_valid, "result after reset")
endmodule
